// ----- sv/lphd_pkg.sv -----
// Shared types and constants for the length-prefixed header deframer.
package lphd_pkg;

  // Width of one stream byte and of the frame length counter.
  localparam int ByteW  = 8;
  localparam int FrameW = 32;
  localparam int AccW   = 24;
  localparam int KindW  = 4;

  // Label given to every byte that leaves the block.
  typedef enum logic [KindW-1:0] {
    K_LEN     = 4'd0,
    K_KEYLEN  = 4'd1,
    K_KEY     = 4'd2,
    K_VALLEN  = 4'd3,
    K_VAL     = 4'd4,
    K_HDREND  = 4'd5,
    K_PAYLOAD = 4'd6,
    K_ERROR   = 4'd7,
    K_DISCARD = 4'd8,
    K_EMPTY   = 4'd9
  } kind_t;

endpackage

// ----- sv/length_prefixed_header_deframer.sv -----
// Top level of the length-prefixed header deframer: byte classifier and output register.
//
// Each accepted byte is labelled combinationally and appears on the master side in the cycle
// after it is accepted, so the block sustains one beat per cycle if m_tready is high; the rate
// rests on the frame counter (a 32-bit decrement, compare) and the field counter. A frame opens
// with a 4-byte big-endian length, followed by key/value header pairs, a zero byte ending the
// header, and payload to the end of the frame. A field length that reaches the bytes left in the
// frame is labelled as an error and the rest of the frame is discarded. A zero-length frame is
// reported on its fourth length byte. The output register holds one labelled beat and a new
// input beat is taken whenever that register is empty or being drained in the same cycle.
module length_prefixed_header_deframer
  import lphd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Slave side
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [ByteW-1:0] s_tdata,   // [7:0] rx_byte
  // Master side
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [ByteW-1:0] m_tdata,   // [7:0] data_byte
  output logic [KindW-1:0] m_tuser,   // [3:0] kind
  output logic             m_tlast    // end_of_frame
);

  typedef enum logic [3:0] {
    PH_LEN     = 4'd0,
    PH_KEYLEN  = 4'd1,
    PH_KEY     = 4'd2,
    PH_VALLEN  = 4'd3,
    PH_VAL     = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_DISCARD = 4'd6
  } phase_t;

  phase_t              phase, phase_next;
  logic [1:0]          length_byte_count, length_byte_count_next;
  logic [AccW-1:0]     length_accumulator, length_accumulator_next;
  logic [FrameW-1:0]   frame_remaining, frame_remaining_next;
  logic [ByteW-1:0]    field_remaining, field_remaining_next;
  logic [ByteW-1:0]    field_dec;
  logic [FrameW-1:0]   after;
  logic [FrameW-1:0]   byte_wide;
  logic                too_long;
  kind_t               kind_next;
  logic                eof_next;
  logic                accept;

  // The input is taken whenever the output register is free or drains this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign after     = frame_remaining - FrameW'(1);
  assign byte_wide = FrameW'(s_tdata);
  assign too_long  = byte_wide >= after;
  assign field_dec = field_remaining - ByteW'(1);

  // Classification of the incoming byte and next state.
  always_comb begin
    phase_next              = phase;
    length_byte_count_next  = length_byte_count;
    length_accumulator_next = length_accumulator;
    frame_remaining_next    = frame_remaining;
    field_remaining_next    = field_remaining;
    kind_next               = K_LEN;
    eof_next                = 1'b0;

    if (phase == PH_LEN || frame_remaining == '0) begin
      // Frame length bytes, most significant first.
      if (length_byte_count != 2'd3) begin
        length_accumulator_next = {length_accumulator[AccW-ByteW-1:0], s_tdata};
        length_byte_count_next  = length_byte_count + 2'd1;
        phase_next              = PH_LEN;
        kind_next               = K_LEN;
      end else begin
        frame_remaining_next    = {length_accumulator, s_tdata};
        length_accumulator_next = '0;
        length_byte_count_next  = 2'd0;
        if ({length_accumulator, s_tdata} == '0) begin
          kind_next  = K_EMPTY;
          eof_next   = 1'b1;
          phase_next = PH_LEN;
        end else begin
          kind_next  = K_LEN;
          phase_next = PH_KEYLEN;
        end
      end
    end else begin
      // Message byte: header field, payload or discard.
      case (phase)
        PH_KEYLEN: begin
          if (s_tdata == '0) begin
            kind_next  = K_HDREND;
            phase_next = PH_PAYLOAD;
          end else if (too_long) begin
            kind_next  = K_ERROR;
            phase_next = PH_DISCARD;
          end else begin
            kind_next            = K_KEYLEN;
            field_remaining_next = s_tdata;
            phase_next           = PH_KEY;
          end
        end
        PH_KEY: begin
          kind_next            = K_KEY;
          field_remaining_next = field_dec;
          if (field_dec == '0) phase_next = PH_VALLEN;
        end
        PH_VALLEN: begin
          if (too_long) begin
            kind_next  = K_ERROR;
            phase_next = PH_DISCARD;
          end else begin
            kind_next            = K_VALLEN;
            field_remaining_next = s_tdata;
            phase_next           = (s_tdata == '0) ? PH_KEYLEN : PH_VAL;
          end
        end
        PH_VAL: begin
          kind_next            = K_VAL;
          field_remaining_next = field_dec;
          if (field_dec == '0) phase_next = PH_KEYLEN;
        end
        PH_PAYLOAD: begin
          kind_next = K_PAYLOAD;
        end
        default: begin
          kind_next  = K_DISCARD;
          phase_next = PH_DISCARD;
        end
      endcase
      frame_remaining_next = after;
      // Last byte of the frame returns the parser to the length phase.
      if (after == '0) begin
        eof_next             = 1'b1;
        phase_next           = PH_LEN;
        field_remaining_next = '0;
      end
    end
  end

  // Parser state, updated on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_LEN;
      length_byte_count  <= 2'd0;
      length_accumulator <= '0;
      frame_remaining    <= '0;
      field_remaining    <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      length_byte_count  <= length_byte_count_next;
      length_accumulator <= length_accumulator_next;
      frame_remaining    <= frame_remaining_next;
      field_remaining    <= field_remaining_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= s_tdata;
      m_tuser <= kind_next;
      m_tlast <= eof_next;
    end
  end

  // An exhausted frame counter only occurs while length bytes are due.
  a_frame_done_in_len: assert property (@(posedge clk) disable iff (rst)
    frame_remaining == '0 |-> phase == PH_LEN)
    else $error("frame counter empty outside the length phase");

  // A partly collected length means the parser is in the length phase.
  a_len_count_phase: assert property (@(posedge clk) disable iff (rst)
    length_byte_count != 2'd0 |-> phase == PH_LEN)
    else $error("length bytes pending outside the length phase");

  // Inside a key or value the field counter has bytes left.
  a_field_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_KEY || phase == PH_VAL) |-> field_remaining != '0)
    else $error("field counter empty inside a field");

  // An empty-frame beat always closes its frame.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == K_EMPTY) |-> m_tlast)
    else $error("empty frame beat without tlast");

endmodule

// ----- bench/lphd_label_checker.sv -----
// Label checker for the deframer: predicts the label of every accepted byte and compares.
module lphd_label_checker
  import lphd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [ByteW-1:0] s_tdata,   // [7:0] rx_byte
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [ByteW-1:0] m_tdata,   // [7:0] data_byte
  input  logic [KindW-1:0] m_tuser,   // [3:0] kind
  input  logic             m_tlast,   // end_of_frame
  output int               mismatch_count,
  output int               labels_pending,
  output int               beats_checked,
  output int               frames_closed,
  output int               field_errors
);

  typedef enum logic [3:0] {
    ST_LEN,
    ST_KEYLEN,
    ST_KEY,
    ST_VALLEN,
    ST_VAL,
    ST_PAYLOAD,
    ST_DISCARD
  } frame_phase_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] data;
    logic             last;
  } labelled_byte_t;

  // Predicted deframer state.
  frame_phase_t      ph;
  logic [1:0]        len_count;
  logic [AccW-1:0]   len_acc;
  logic [FrameW-1:0] frame_left;
  logic [ByteW-1:0]  field_left;

  labelled_byte_t labels_due[$];
  int mismatches;
  int beats;
  int frames;
  int overlong;

  assign mismatch_count = mismatches;
  assign beats_checked  = beats;
  assign frames_closed  = frames;
  assign field_errors   = overlong;

  // Works out the label of one byte and advances the predicted state.
  function automatic labelled_byte_t label_byte(input logic [ByteW-1:0] b);
    labelled_byte_t    r;
    logic [FrameW-1:0] left_after;
    r.kind = K_LEN;
    r.data = b;
    r.last = 1'b0;
    if (ph == ST_LEN || frame_left == '0) begin
      // One of the four big-endian length bytes.
      if (len_count < 2'd3) begin
        len_acc   = {len_acc[AccW-9:0], b};
        len_count = len_count + 2'd1;
        ph        = ST_LEN;
      end else begin
        frame_left = {len_acc, b};
        len_acc    = '0;
        len_count  = '0;
        if (frame_left == '0) begin
          r.kind = K_EMPTY;
          r.last = 1'b1;
          ph     = ST_LEN;
        end else begin
          ph = ST_KEYLEN;
        end
      end
    end else begin
      left_after = frame_left - 32'd1;
      case (ph)
        ST_KEYLEN: begin
          if (b == 8'h00) begin
            r.kind = K_HDREND;
            ph     = ST_PAYLOAD;
          end else if ({24'd0, b} >= left_after) begin
            r.kind = K_ERROR;
            ph     = ST_DISCARD;
          end else begin
            r.kind     = K_KEYLEN;
            field_left = b;
            ph         = ST_KEY;
          end
        end
        ST_KEY: begin
          r.kind     = K_KEY;
          field_left = field_left - 8'd1;
          if (field_left == '0) ph = ST_VALLEN;
        end
        ST_VALLEN: begin
          if ({24'd0, b} >= left_after) begin
            r.kind = K_ERROR;
            ph     = ST_DISCARD;
          end else begin
            r.kind     = K_VALLEN;
            field_left = b;
            ph         = (b == 8'h00) ? ST_KEYLEN : ST_VAL;
          end
        end
        ST_VAL: begin
          r.kind     = K_VAL;
          field_left = field_left - 8'd1;
          if (field_left == '0) ph = ST_KEYLEN;
        end
        ST_PAYLOAD: begin
          r.kind = K_PAYLOAD;
        end
        default: begin
          r.kind = K_DISCARD;
          ph     = ST_DISCARD;
        end
      endcase
      frame_left = left_after;
      if (left_after == '0) begin
        r.last     = 1'b1;
        ph         = ST_LEN;
        field_left = '0;
      end
    end
    return r;
  endfunction

  // Predict on every accepted input beat, compare on every accepted output beat.
  always @(posedge clk) begin
    labelled_byte_t want;
    if (rst) begin
      ph         = ST_LEN;
      len_count  = '0;
      len_acc    = '0;
      frame_left = '0;
      field_left = '0;
      labels_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        want       = label_byte(s_tdata);
        labels_due = {labels_due, want};
      end
      if (m_tvalid && m_tready) begin
        beats++;
        if (m_tlast) frames++;
        if (m_tuser == K_ERROR) overlong++;
        if (labels_due.size() == 0) begin
          mismatches++;
          $display("%0t: expected no beat, actual kind %0d data %02h last %0b", $time,
                   m_tuser, m_tdata, m_tlast);
        end else begin
          want = labels_due.pop_front();
          if (m_tuser != want.kind) begin
            mismatches++;
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_tuser);
          end
          if (m_tdata != want.data) begin
            mismatches++;
            $display("%0t: data expected %02h actual %02h", $time, want.data, m_tdata);
          end
          if (m_tlast != want.last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, m_tlast);
          end
        end
      end
    end
    labels_pending <= labels_due.size();
  end

endmodule

// ----- bench/length_prefixed_header_deframer_test.sv -----
// Top of the deframer testbench: clock, reset, framed byte stimulus and the verdict.
module length_prefixed_header_deframer_test;
  import lphd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int PhaseTarget = 517;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [ByteW-1:0] s_tdata;    // [7:0] rx_byte
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [ByteW-1:0] m_tdata;    // [7:0] data_byte
  logic [KindW-1:0] m_tuser;    // [3:0] kind
  logic             m_tlast;    // end_of_frame

  int mismatch_count;
  int labels_pending;
  int beats_checked;
  int frames_closed;
  int field_errors;
  int send_gap_pct  = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  logic [ByteW-1:0] stream_q[$];

  length_prefixed_header_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  lphd_label_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .labels_pending (labels_pending),
    .beats_checked  (beats_checked),
    .frames_closed  (frames_closed),
    .field_errors   (field_errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random according to the current pattern.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("length_prefixed_header_deframer_test: errors");
      $finish;
    end
  end

  // Offers one beat, with random gaps ahead of it, and waits for it to be taken.
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Appends one frame: empty, well formed, well formed then broken, or random noise.
  task automatic add_frame();
    logic [ByteW-1:0]  msg[$];
    int                len_pos[$];
    int                roll;
    int                pairs;
    int                klen;
    int                vlen;
    int                plen;
    int                cut;
    logic [FrameW-1:0] flen;
    roll = $urandom_range(99);
    if (roll < 6) begin
      flen = '0;
    end else if (roll < 88) begin
      pairs = $urandom_range(3);
      for (int p = 0; p < pairs; p++) begin
        klen = ($urandom_range(49) == 0) ? 255 : $urandom_range(1, 5);
        vlen = ($urandom_range(49) == 0) ? 255 : $urandom_range(0, 5);
        len_pos = {len_pos, msg.size()};
        msg = {msg, klen[7:0]};
        repeat (klen) msg = {msg, 8'($urandom_range(255))};
        len_pos = {len_pos, msg.size()};
        msg = {msg, vlen[7:0]};
        repeat (vlen) msg = {msg, 8'($urandom_range(255))};
      end
      len_pos = {len_pos, msg.size()};
      msg = {msg, 8'h00};
      plen = ($urandom_range(99) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 8);
      repeat (plen) msg = {msg, 8'($urandom_range(255))};
      // Broken frames: a length byte overwritten, and sometimes the frame cut short.
      if (roll >= 72) begin
        msg[len_pos[$urandom_range(len_pos.size() - 1)]] = 8'($urandom_range(1, 255));
        if ($urandom_range(1) == 1) begin
          cut = $urandom_range(1, msg.size());
          while (msg.size() > cut) void'(msg.pop_back());
        end
      end
      flen = msg.size();
    end else begin
      plen = $urandom_range(1, 12);
      repeat (plen) msg = {msg, 8'($urandom_range(255))};
      flen = msg.size();
    end
    stream_q = {stream_q, flen[31:24]};
    stream_q = {stream_q, flen[23:16]};
    stream_q = {stream_q, flen[15:8]};
    stream_q = {stream_q, flen[7:0]};
    foreach (msg[i]) stream_q = {stream_q, msg[i]};
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    rst      = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed frames: an empty frame; a key with an empty value and the header end
    // as the last byte; a key length of 255 that overruns the frame, then discards;
    // a key, a one-byte value, the header end and a single payload byte.
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h04, 8'h01, 8'h41, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h80, 8'h7F,
                 8'h00, 8'h00, 8'h00, 8'h06, 8'h01, 8'h10, 8'h01, 8'hEF, 8'h00, 8'hFF};

    // Three stall patterns: receiver-heavy stalls, sender-heavy gaps, then none.
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          send_gap_pct   = 36;
          recv_stall_pct = 50;
        end
        1: begin
          send_gap_pct   = 50;
          recv_stall_pct = 36;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (stream_q.size() < PhaseTarget) add_frame();
      while (stream_q.size() > 0) send_byte(stream_q.pop_front());
    end
    s_tvalid <= 1'b0;

    // Drain the output register, then idle briefly before the verdict.
    @(posedge clk);
    while (labels_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d labelled beats over %0d frame ends, %0d over-long fields,",
             beats_checked, frames_closed, field_errors);
    $display("under sender gaps, receiver stalls and a full-rate stretch.");
    if (mismatch_count == 0 && labels_pending == 0) begin
      $display("length_prefixed_header_deframer_test: clean");
    end else begin
      $display("length_prefixed_header_deframer_test: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lphd_pkg.sv
sv/length_prefixed_header_deframer.sv
bench/lphd_label_checker.sv
bench/length_prefixed_header_deframer_test.sv
